// File: rtl/cdhir_pkg.sv
// ----------------------------------------------------------------------------
// CD-ROM host interface register file - shared definitions
// Request and result formats, operation and register codes, and the
// constants of the sector header conversion.
// ----------------------------------------------------------------------------
package cdhir_pkg;

   // Operation codes on the request channel.
   localparam logic [2:0] OP_SELECT   = 3'd0;
   localparam logic [2:0] OP_READ     = 3'd1;
   localparam logic [2:0] OP_WRITE    = 3'd2;
   localparam logic [2:0] OP_SECTOR   = 3'd3;
   localparam logic [2:0] OP_XFER_END = 3'd4;

   // Read map.
   localparam logic [3:0] RD_ZERO   = 4'd0;
   localparam logic [3:0] RD_STATUS = 4'd1;
   localparam logic [3:0] RD_CNT_LO = 4'd2;
   localparam logic [3:0] RD_CNT_HI = 4'd3;
   localparam logic [3:0] RD_HDR0   = 4'd4;
   localparam logic [3:0] RD_HDR1   = 4'd5;
   localparam logic [3:0] RD_HDR2   = 4'd6;
   localparam logic [3:0] RD_HDR3   = 4'd7;
   localparam logic [3:0] RD_BLK_LO = 4'd8;
   localparam logic [3:0] RD_BLK_HI = 4'd9;
   localparam logic [3:0] RD_WA_LO  = 4'd10;
   localparam logic [3:0] RD_WA_HI  = 4'd11;
   localparam logic [3:0] RD_STS0   = 4'd12;
   localparam logic [3:0] RD_STS1   = 4'd13;
   localparam logic [3:0] RD_STS2   = 4'd14;
   localparam logic [3:0] RD_STS3   = 4'd15;

   // Write map.
   localparam logic [3:0] WR_CTRL       = 4'd1;
   localparam logic [3:0] WR_CNT_LO     = 4'd2;
   localparam logic [3:0] WR_CNT_HI     = 4'd3;
   localparam logic [3:0] WR_DA_LO      = 4'd4;
   localparam logic [3:0] WR_DA_HI      = 4'd5;
   localparam logic [3:0] WR_XFER_TRIG  = 4'd6;
   localparam logic [3:0] WR_XFER_ACK   = 4'd7;
   localparam logic [3:0] WR_WA_LO      = 4'd8;
   localparam logic [3:0] WR_WA_HI      = 4'd9;
   localparam logic [3:0] WR_CTRL0      = 4'd10;
   localparam logic [3:0] WR_CTRL1      = 4'd11;
   localparam logic [3:0] WR_BLK_LO     = 4'd12;
   localparam logic [3:0] WR_BLK_HI     = 4'd13;
   localparam logic [3:0] WR_FULL_RESET = 4'd15;

   // Interface status flags, all active low.
   localparam logic [7:0] ST_XFER_END = 8'h40;
   localparam logic [7:0] ST_DECODE   = 8'h20;
   localparam logic [7:0] ST_BUSY     = 8'h08;
   localparam logic [7:0] ST_FLAGS    = ST_XFER_END | ST_DECODE | ST_BUSY;

   localparam logic [7:0]  STATUS_RESET     = 8'hFF;
   localparam logic [15:0] WRITE_ADDR_RESET = 16'h0930;
   localparam logic [15:0] SECTOR_STRIDE    = 16'd2352;
   localparam logic [7:0]  HEADER_MODE      = 8'h01;
   localparam logic [7:0]  SECTOR_STS0      = 8'h80;
   localparam logic [7:0]  STS2_MASK_SHORT  = 8'h08;
   localparam logic [7:0]  STS2_MASK_LONG   = 8'h0C;

   // Header conversion: address offset, frames per minute and per second,
   // and the reciprocals used for the two constant divisions.
   localparam logic [19:0] LBA_OFFSET  = 20'd150;
   localparam logic [19:0] FRAMES_MIN  = 20'd4500;
   localparam logic [12:0] FRAMES_SEC  = 13'd75;
   localparam logic [39:0] MIN_RECIP   = 40'd954438;   // ceil(2^32 / 4500)
   localparam logic [21:0] SEC_RECIP   = 22'd874;      // ceil(2^16 / 75)

   localparam int FRONT_STAGES = 6;
   localparam int QUEUE_DEPTH  = 4;
   localparam int QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_SELECT,
      CMD_READ,
      CMD_WRITE,
      CMD_SECTOR,
      CMD_XFER_END
   } cmd_kind_type;

   typedef struct packed {
      logic [2:0]  operation;
      logic [7:0]  bus_data;
      logic [18:0] sector_lba;
   } req_type;

   typedef struct packed {
      logic [7:0]  read_data;
      logic [7:0]  interrupt_status;
      logic [15:0] transfer_address;
      logic [11:0] transfer_count;
   } rsp_type;

   // A classified request on its way to the register file.
   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   bus_data;
      logic [7:0]   hdr_min;
      logic [7:0]   hdr_sec;
      logic [7:0]   hdr_frm;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// File: rtl/cdhir_front.sv
// ----------------------------------------------------------------------------
// CD-ROM host interface - request front end
// Accepts requests, classifies the operation and converts the sector address
// into a BCD minute/second/frame header over a short pipeline.
// ----------------------------------------------------------------------------
module cdhir_front
   import cdhir_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   input  queue_status_type q_status,
   output logic             push,
   output cmd_type          push_cmd
);

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   bus_data;
      logic [19:0]  addr;
      logic [6:0]   minute;
      logic [12:0]  rem;
      logic [5:0]   sec;
      logic [6:0]   frame;
      logic [7:0]   min_bcd;
      logic [7:0]   sec_bcd;
      logic [7:0]   frm_bcd;
   } pipe_type;

   localparam int LAST = FRONT_STAGES - 1;

   pipe_type pipe_ff [FRONT_STAGES];
   pipe_type pipe_in [FRONT_STAGES];
   logic     vld_ff  [FRONT_STAGES];
   logic     advance;
   logic [39:0] min_prod;
   logic [21:0] sec_prod;
   logic [19:0] min_span;
   logic [12:0] sec_span;

   // Two-digit BCD byte; the tens digit lands in the high nibble.
   function automatic logic [7:0] bcd_byte(input logic [6:0] v);
      logic [17:0] prod;
      logic [3:0]  tens;
      logic [6:0]  ones;
      prod = 18'(v) * 18'd205;
      tens = prod[14:11];
      ones = v - 7'({tens, 3'b000}) - 7'({tens, 1'b0});
      return {tens, ones[3:0]};
   endfunction

   assign advance   = !(vld_ff[LAST] && q_status.full);
   assign req_stall = !advance;
   assign push      = advance && vld_ff[LAST];

   always_comb begin
      for (int i = 1; i < FRONT_STAGES; i++) begin
         pipe_in[i] = pipe_ff[i-1];
      end

      pipe_in[0]          = pipe_ff[0];
      pipe_in[0].bus_data = req_data.bus_data;
      pipe_in[0].addr     = 20'(req_data.sector_lba) + LBA_OFFSET;
      case (req_data.operation)
         OP_SELECT:   pipe_in[0].kind = CMD_SELECT;
         OP_READ:     pipe_in[0].kind = CMD_READ;
         OP_WRITE:    pipe_in[0].kind = CMD_WRITE;
         OP_SECTOR:   pipe_in[0].kind = CMD_SECTOR;
         OP_XFER_END: pipe_in[0].kind = CMD_XFER_END;
         default:     pipe_in[0].kind = CMD_NONE;
      endcase

      // Minute by reciprocal multiply; exact for every address a 19-bit LBA gives.
      min_prod = 40'(pipe_ff[0].addr) * MIN_RECIP;
      pipe_in[1].minute = min_prod[38:32];

      min_span = 20'(pipe_ff[1].minute) * FRAMES_MIN;
      pipe_in[2].rem     = 13'(pipe_ff[1].addr - min_span);
      pipe_in[2].min_bcd = bcd_byte(pipe_ff[1].minute);

      sec_prod = 22'(pipe_ff[2].rem) * SEC_RECIP;
      pipe_in[3].sec = sec_prod[21:16];

      sec_span = 13'(pipe_ff[3].sec) * FRAMES_SEC;
      pipe_in[4].frame   = 7'(pipe_ff[3].rem - sec_span);
      pipe_in[4].sec_bcd = bcd_byte({1'b0, pipe_ff[3].sec});

      pipe_in[5].frm_bcd = bcd_byte(pipe_ff[4].frame);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < FRONT_STAGES; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else if (advance) begin
         vld_ff[0] <= req_valid;
         for (int i = 1; i < FRONT_STAGES; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < FRONT_STAGES; i++) begin
            pipe_ff[i] <= pipe_in[i];
         end
      end
   end

   assign push_cmd.kind     = pipe_ff[LAST].kind;
   assign push_cmd.bus_data = pipe_ff[LAST].bus_data;
   assign push_cmd.hdr_min  = pipe_ff[LAST].min_bcd;
   assign push_cmd.hdr_sec  = pipe_ff[LAST].sec_bcd;
   assign push_cmd.hdr_frm  = pipe_ff[LAST].frm_bcd;

endmodule

// File: rtl/cdhir_queue.sv
// ----------------------------------------------------------------------------
// CD-ROM host interface - command queue
// Short first-in first-out queue between the front end and the register file.
// ----------------------------------------------------------------------------
module cdhir_queue
   import cdhir_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  cmd_type          push_cmd,
   input  logic             pop,
   output cmd_type          pop_cmd,
   output queue_status_type q_status
);

   cmd_type                entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff;
   logic [QUEUE_CNT_W-1:0] cnt_ff;

   assign q_status.full  = (cnt_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign q_status.empty = (cnt_ff == '0);
   assign pop_cmd        = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// File: rtl/cdhir_back.sv
// ----------------------------------------------------------------------------
// CD-ROM host interface - register file back end
// Executes one classified request per cycle against the register state, unless
// a stalled result holds it, and keeps the result in an output register.
// ----------------------------------------------------------------------------
module cdhir_back
   import cdhir_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  queue_status_type q_status,
   input  cmd_type          cmd,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data
);

   logic [3:0]  ptr_ff,      ptr_in,      ptr_bump;
   logic [7:0]  ctrl_ff,     ctrl_in;
   logic [7:0]  status_ff,   status_in;
   logic [11:0] count_ff,    count_in;
   logic [15:0] data_addr_ff, data_addr_in;
   logic [15:0] wr_addr_ff,  wr_addr_in;
   logic [15:0] blk_ptr_ff,  blk_ptr_in;
   logic [7:0]  ctrl0_ff,    ctrl0_in;
   logic [7:0]  ctrl1_ff,    ctrl1_in;
   logic        dec_on_ff,   dec_on_in;
   logic [7:0]  hdr_ff [4];
   logic [7:0]  hdr_in [4];
   logic [7:0]  sts_ff [4];
   logic [7:0]  sts_in [4];
   logic [7:0]  rd_data;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff;

   assign pop = !q_status.empty && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      if (ptr_ff == '0) begin
         ptr_bump = '0;
      end else if (ptr_ff == 4'hF) begin
         ptr_bump = 4'h1;
      end else begin
         ptr_bump = ptr_ff + 4'h1;
      end
   end

   always_comb begin
      ptr_in       = ptr_ff;
      ctrl_in      = ctrl_ff;
      status_in    = status_ff;
      count_in     = count_ff;
      data_addr_in = data_addr_ff;
      wr_addr_in   = wr_addr_ff;
      blk_ptr_in   = blk_ptr_ff;
      ctrl0_in     = ctrl0_ff;
      ctrl1_in     = ctrl1_ff;
      dec_on_in    = dec_on_ff;
      hdr_in       = hdr_ff;
      sts_in       = sts_ff;
      rd_data      = '0;

      if (pop) begin
         case (cmd.kind)
            CMD_SELECT: begin
               ptr_in = cmd.bus_data[3:0];
            end
            CMD_READ: begin
               ptr_in = ptr_bump;
               case (ptr_ff)
                  RD_STATUS: rd_data = status_ff;
                  RD_CNT_LO: rd_data = count_ff[7:0];
                  RD_CNT_HI: rd_data = {4'h0, count_ff[11:8]};
                  RD_HDR0, RD_HDR1, RD_HDR2, RD_HDR3: begin
                     rd_data = ctrl1_ff[0] ? 8'h00 : hdr_ff[ptr_ff[1:0]];
                  end
                  RD_BLK_LO: rd_data = blk_ptr_ff[7:0];
                  RD_BLK_HI: rd_data = blk_ptr_ff[15:8];
                  RD_WA_LO:  rd_data = wr_addr_ff[7:0];
                  RD_WA_HI:  rd_data = wr_addr_ff[15:8];
                  RD_STS0, RD_STS1, RD_STS2: rd_data = sts_ff[ptr_ff[1:0]];
                  RD_STS3: begin
                     rd_data   = sts_ff[3];
                     status_in = status_ff | ST_DECODE;
                  end
                  default: rd_data = '0;
               endcase
            end
            CMD_WRITE: begin
               ptr_in = ptr_bump;
               case (ptr_ff)
                  WR_CTRL:   ctrl_in = cmd.bus_data;
                  WR_CNT_LO: count_in = {count_ff[11:8], cmd.bus_data};
                  WR_CNT_HI: count_in = {cmd.bus_data[3:0], count_ff[7:0]};
                  WR_DA_LO:  data_addr_in = {data_addr_ff[15:8], cmd.bus_data};
                  WR_DA_HI:  data_addr_in = {cmd.bus_data, data_addr_ff[7:0]};
                  WR_XFER_TRIG: begin
                     if (ctrl_ff[1]) begin
                        status_in = status_ff & ~ST_BUSY;
                     end
                  end
                  WR_XFER_ACK: status_in = status_ff | ST_XFER_END;
                  WR_WA_LO:  wr_addr_in = {wr_addr_ff[15:8], cmd.bus_data};
                  WR_WA_HI:  wr_addr_in = {cmd.bus_data, wr_addr_ff[7:0]};
                  WR_CTRL0: begin
                     ctrl0_in  = cmd.bus_data;
                     dec_on_in = cmd.bus_data[7];
                  end
                  WR_CTRL1:  ctrl1_in = cmd.bus_data;
                  WR_BLK_LO: blk_ptr_in = {blk_ptr_ff[15:8], cmd.bus_data};
                  WR_BLK_HI: blk_ptr_in = {cmd.bus_data, blk_ptr_ff[7:0]};
                  WR_FULL_RESET: begin
                     ptr_in       = '0;
                     ctrl_in      = '0;
                     status_in    = STATUS_RESET;
                     count_in     = '0;
                     data_addr_in = '0;
                     wr_addr_in   = WRITE_ADDR_RESET;
                     blk_ptr_in   = '0;
                     ctrl0_in     = '0;
                     ctrl1_in     = '0;
                     dec_on_in    = 1'b0;
                     for (int i = 0; i < 4; i++) begin
                        hdr_in[i] = '0;
                        sts_in[i] = '0;
                     end
                  end
                  default: ;
               endcase
            end
            CMD_SECTOR: begin
               if (dec_on_ff) begin
                  hdr_in[0]  = cmd.hdr_min;
                  hdr_in[1]  = cmd.hdr_sec;
                  hdr_in[2]  = cmd.hdr_frm;
                  hdr_in[3]  = HEADER_MODE;
                  blk_ptr_in = wr_addr_ff;
                  wr_addr_in = wr_addr_ff + SECTOR_STRIDE;
                  sts_in[0]  = SECTOR_STS0;
                  sts_in[1]  = '0;
                  sts_in[2]  = ctrl1_ff & (ctrl0_ff[4] ? STS2_MASK_SHORT : STS2_MASK_LONG);
                  sts_in[3]  = '0;
                  status_in  = status_ff & ~ST_DECODE;
               end
            end
            CMD_XFER_END: begin
               status_in    = (status_ff | ST_BUSY) & ~ST_XFER_END;
               data_addr_in = data_addr_ff + 16'(count_ff) + 16'd1;
               count_in     = '0;
            end
            default: ;
         endcase
      end

      rsp_valid_in = pop || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff       <= '0;
         ctrl_ff      <= '0;
         status_ff    <= STATUS_RESET;
         count_ff     <= '0;
         data_addr_ff <= '0;
         wr_addr_ff   <= WRITE_ADDR_RESET;
         blk_ptr_ff   <= '0;
         ctrl0_ff     <= '0;
         ctrl1_ff     <= '0;
         dec_on_ff    <= 1'b0;
         for (int i = 0; i < 4; i++) begin
            hdr_ff[i] <= '0;
            sts_ff[i] <= '0;
         end
         rsp_valid_ff <= 1'b0;
      end else begin
         ptr_ff       <= ptr_in;
         ctrl_ff      <= ctrl_in;
         status_ff    <= status_in;
         count_ff     <= count_in;
         data_addr_ff <= data_addr_in;
         wr_addr_ff   <= wr_addr_in;
         blk_ptr_ff   <= blk_ptr_in;
         ctrl0_ff     <= ctrl0_in;
         ctrl1_ff     <= ctrl1_in;
         dec_on_ff    <= dec_on_in;
         hdr_ff       <= hdr_in;
         sts_ff       <= sts_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_data_ff.read_data        <= rd_data;
         rsp_data_ff.interrupt_status <= status_in;
         rsp_data_ff.transfer_address <= data_addr_in;
         rsp_data_ff.transfer_count   <= count_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: rtl/cdrom_host_interface_registers_unit.sv
// ----------------------------------------------------------------------------
// CD-ROM host interface register file - top level
// Host-visible register file of a CD-ROM decoder controller, with sector
// header capture and transfer bookkeeping.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                          Direction   Carries
//   request   req_valid, req_stall, req_data in          operation, bus data, sector LBA
//   result    rsp_valid, rsp_stall, rsp_data out         read data, status, transfer address/count
//
// One request is accepted per cycle while req_stall is low, and each request
// gives exactly one result. A request passes through six front-end stages,
// which convert the sector address into BCD minute/second/frame, then through
// the command queue, and the register file writes the output register. Reset
// is synchronous and clears the valid flags, queue pointers and register file
// state to power-on values, not the pipeline, queue and result data. A stall
// on the result side fills the four-entry queue first; the request side stalls
// only once the last front-end stage holds a request and the queue is full.
//
// The front end classifies each request and computes the sector header even
// when it is not needed, so the register file itself needs no pipeline of
// its own. The register pointer, interrupt flags and addresses live only in
// the register file, which keeps the order of requests intact.
module cdrom_host_interface_registers_unit
   import cdhir_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   queue_status_type q_status;
   logic             push;
   cmd_type          push_cmd;
   logic             pop;
   cmd_type          pop_cmd;

   // Classification and header conversion.
   cdhir_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_status  (q_status),
      .push      (push),
      .push_cmd  (push_cmd)
   );

   // Queue that lets the front end and the register file stall apart.
   cdhir_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .pop_cmd  (pop_cmd),
      .q_status (q_status)
   );

   // Register file and result register.
   cdhir_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .cmd       (pop_cmd),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// File: rtl/cdhir_checker.sv
// ----------------------------------------------------------------------------
// CD-ROM host interface - port checker
// Watches the top-level ports for result ordering and status flag rules.
// ----------------------------------------------------------------------------
module cdhir_checker
   import cdhir_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   localparam int PEND_W = $clog2(FRONT_STAGES + QUEUE_DEPTH + 2) + 1;

   logic [PEND_W-1:0] pending_ff;
   logic              req_take;
   logic              rsp_take;

   assign req_take = req_valid && !req_stall;
   assign rsp_take = rsp_valid && !rsp_stall;

   // Requests accepted whose results are not yet delivered.
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else if (req_take && !rsp_take) begin
         pending_ff <= pending_ff + 1'b1;
      end else if (rsp_take && !req_take) begin
         pending_ff <= pending_ff - 1'b1;
      end
   end

   // A stalled result holds its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // No result leaves without an accepted request behind it.
   assert property (@(posedge clock) disable iff (reset)
      rsp_take |-> (pending_ff != '0) || req_take)
      else $error("result delivered without a request");

   // Only the three interrupt flags of the status byte may ever be low.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.interrupt_status | ST_FLAGS) == 8'hFF)
      else $error("status byte has a fixed bit cleared");

   // Reset empties the result register.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind cdrom_host_interface_registers_unit cdhir_checker u_checker (.*);

// File: tb/sv/cdrom_host_interface_registers_unit_tb.sv
// ----------------------------------------------------------------------------
// CD-ROM host interface register file - self-checking testbench
// Drives bus requests (register select, read, write, sector decoded, transfer
// end) into the register file and checks each result against a pinned value
// or an in-bench register file model kept in step with every accepted request.
// ----------------------------------------------------------------------------
module cdrom_host_interface_registers_unit_tb;
   import cdhir_pkg::*;

   // Operation codes that the block accepts but ignores.
   localparam logic [2:0] OP_SPARE_LO = 3'd5;
   localparam logic [2:0] OP_SPARE_HI = 3'd7;

   // Disc time conversion: two seconds of lead-in, 75 frames per second.
   localparam int unsigned FRAME_BIAS      = 150;
   localparam int unsigned FRAMES_PER_SEC  = 75;
   localparam int unsigned SECS_PER_MIN    = 60;
   localparam int unsigned FRAMES_PER_MIN  = 4500;
   localparam int unsigned LBA_TOP         = 449849;

   localparam int RANDOM_REQUESTS = 1500;
   localparam int QUIET_TAIL      = 200;
   localparam int HOLD_OFF_CYCLES = 100;
   localparam int HOLD_OFF_AFTER  = 400;
   localparam int DRAIN_CYCLES    = 20;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   cdrom_host_interface_registers_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // The run is cut off here if the block hangs; the slowest correct run
   // takes well under a tenth of this.
   initial begin
      #3000000;
      $display("cdrom_host_interface_registers_unit verification failed");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Register file model. It holds its own copy of every host-visible
   // register and is advanced once per accepted request, in request order.
   // -------------------------------------------------------------------------
   logic [3:0]  sel_reg;
   logic [7:0]  host_ctrl;
   logic [7:0]  irq_flags;
   logic [11:0] xfer_cnt;
   logic [15:0] xfer_addr;
   logic [15:0] wr_ptr;
   logic [15:0] blk_addr;
   logic [7:0]  ctrl0_q;
   logic [7:0]  ctrl1_q;
   logic        decode_en;
   logic [7:0]  hdr_q [4];
   logic [7:0]  sts_q [4];

   // Results still owed by the block, oldest first.
   rsp_type host_results_due [$];

   int mismatches      = 0;
   int results_checked = 0;
   bit quiet_tail      = 1'b0;

   function automatic void clear_register_file();
      sel_reg   = 4'd0;
      host_ctrl = 8'h00;
      irq_flags = STATUS_RESET;
      xfer_cnt  = 12'h000;
      xfer_addr = 16'h0000;
      wr_ptr    = WRITE_ADDR_RESET;
      blk_addr  = 16'h0000;
      ctrl0_q   = 8'h00;
      ctrl1_q   = 8'h00;
      decode_en = 1'b0;
      for (int i = 0; i < 4; i++) begin
         hdr_q[i] = 8'h00;
         sts_q[i] = 8'h00;
      end
   endfunction

   function automatic logic [7:0] to_bcd(input int unsigned v);
      return 8'(((v / 10) << 4) | (v % 10));
   endfunction

   // The pointer walks 1..15 and wraps to 1; parked at 0 it never moves.
   function automatic void advance_pointer();
      if (sel_reg != 4'd0) begin
         sel_reg = (sel_reg == 4'd15) ? 4'd1 : sel_reg + 4'd1;
      end
   endfunction

   function automatic rsp_type host_access_result(input req_type r);
      rsp_type     res;
      logic [3:0]  idx;
      int unsigned frames;
      res = '0;
      idx = sel_reg;
      case (r.operation)
         OP_SELECT: begin
            sel_reg = r.bus_data[3:0];
         end
         OP_READ: begin
            advance_pointer();
            case (idx)
               RD_STATUS: res.read_data = irq_flags;
               RD_CNT_LO: res.read_data = xfer_cnt[7:0];
               RD_CNT_HI: res.read_data = {4'h0, xfer_cnt[11:8]};
               RD_HDR0, RD_HDR1, RD_HDR2, RD_HDR3: begin
                  res.read_data = ctrl1_q[0] ? 8'h00 : hdr_q[idx[1:0]];
               end
               RD_BLK_LO: res.read_data = blk_addr[7:0];
               RD_BLK_HI: res.read_data = blk_addr[15:8];
               RD_WA_LO:  res.read_data = wr_ptr[7:0];
               RD_WA_HI:  res.read_data = wr_ptr[15:8];
               RD_STS0, RD_STS1, RD_STS2: res.read_data = sts_q[idx[1:0]];
               RD_STS3: begin
                  // Reading the last status byte acknowledges the decode.
                  res.read_data = sts_q[3];
                  irq_flags = irq_flags | ST_DECODE;
               end
               default: ;
            endcase
         end
         OP_WRITE: begin
            advance_pointer();
            case (idx)
               WR_CTRL:   host_ctrl = r.bus_data;
               WR_CNT_LO: xfer_cnt[7:0] = r.bus_data;
               WR_CNT_HI: xfer_cnt[11:8] = r.bus_data[3:0];
               WR_DA_LO:  xfer_addr[7:0] = r.bus_data;
               WR_DA_HI:  xfer_addr[15:8] = r.bus_data;
               WR_XFER_TRIG: begin
                  if (host_ctrl[1]) irq_flags = irq_flags & ~ST_BUSY;
               end
               WR_XFER_ACK: irq_flags = irq_flags | ST_XFER_END;
               WR_WA_LO:  wr_ptr[7:0] = r.bus_data;
               WR_WA_HI:  wr_ptr[15:8] = r.bus_data;
               WR_CTRL0: begin
                  ctrl0_q   = r.bus_data;
                  decode_en = r.bus_data[7];
               end
               WR_CTRL1:  ctrl1_q = r.bus_data;
               WR_BLK_LO: blk_addr[7:0] = r.bus_data;
               WR_BLK_HI: blk_addr[15:8] = r.bus_data;
               WR_FULL_RESET: clear_register_file();
               default: ;
            endcase
         end
         OP_SECTOR: begin
            if (decode_en) begin
               frames   = int'(r.sector_lba) + FRAME_BIAS;
               hdr_q[0] = to_bcd(frames / FRAMES_PER_MIN);
               hdr_q[1] = to_bcd((frames / FRAMES_PER_SEC) % SECS_PER_MIN);
               hdr_q[2] = to_bcd(frames % FRAMES_PER_SEC);
               hdr_q[3] = HEADER_MODE;
               blk_addr = wr_ptr;
               wr_ptr   = wr_ptr + SECTOR_STRIDE;
               sts_q[0] = SECTOR_STS0;
               sts_q[1] = 8'h00;
               sts_q[2] = ctrl1_q & (ctrl0_q[4] ? STS2_MASK_SHORT : STS2_MASK_LONG);
               sts_q[3] = 8'h00;
               irq_flags = irq_flags & ~ST_DECODE;
            end
         end
         OP_XFER_END: begin
            irq_flags = irq_flags | ST_BUSY;
            xfer_addr = xfer_addr + {4'h0, xfer_cnt} + 16'd1;
            xfer_cnt  = 12'h000;
            irq_flags = irq_flags & ~ST_XFER_END;
         end
         default: ;
      endcase
      res.interrupt_status = irq_flags;
      res.transfer_address = xfer_addr;
      res.transfer_count   = xfer_cnt;
      return res;
   endfunction

   // -------------------------------------------------------------------------
   // Opening requests. Rows marked pinned carry a result worked out by hand
   // (reset values, all-ones fields and the wrap of the transfer address);
   // the rest take the model's result. Every row still advances the model.
   // -------------------------------------------------------------------------
   typedef struct {
      req_type req;
      bit      pinned;
      rsp_type want;
   } opening_row_type;

   opening_row_type opening [26] = '{
      // Read with the pointer parked at zero after reset.
      '{'{OP_READ,     8'h00, 19'd0},       1'b1, '{8'h00, 8'hFF, 16'h0000, 12'h000}},
      // High nibble of a select is ignored.
      '{'{OP_SELECT,   8'hF1, 19'h7FFFF},   1'b1, '{8'h00, 8'hFF, 16'h0000, 12'h000}},
      '{'{OP_READ,     8'h00, 19'd0},       1'b1, '{8'hFF, 8'hFF, 16'h0000, 12'h000}},
      '{'{OP_WRITE,    8'hFF, 19'd0},       1'b1, '{8'h00, 8'hFF, 16'h0000, 12'h0FF}},
      '{'{OP_WRITE,    8'hFF, 19'd0},       1'b1, '{8'h00, 8'hFF, 16'h0000, 12'hFFF}},
      '{'{OP_WRITE,    8'hFF, 19'd0},       1'b1, '{8'h00, 8'hFF, 16'h00FF, 12'hFFF}},
      '{'{OP_WRITE,    8'hFF, 19'd0},       1'b1, '{8'h00, 8'hFF, 16'hFFFF, 12'hFFF}},
      // Transfer end with the largest count wraps the address.
      '{'{OP_XFER_END, 8'h00, 19'd0},       1'b1, '{8'h00, 8'hBF, 16'h0FFF, 12'h000}},
      '{'{OP_SELECT,   8'h01, 19'd0},       1'b0, '0},
      '{'{OP_WRITE,    8'h02, 19'd0},       1'b0, '0},
      '{'{OP_SELECT,   8'h06, 19'd0},       1'b0, '0},
      '{'{OP_WRITE,    8'h5A, 19'd0},       1'b0, '0},
      '{'{OP_WRITE,    8'hA5, 19'd0},       1'b0, '0},
      '{'{OP_SELECT,   8'hAA, 19'd0},       1'b0, '0},
      '{'{OP_WRITE,    8'h90, 19'd0},       1'b0, '0},
      '{'{OP_WRITE,    8'h0D, 19'd0},       1'b0, '0},
      // Sector addresses: beyond the last minute, zero, and the disc's end.
      '{'{OP_SECTOR,   8'h00, 19'h7FFFF},   1'b0, '0},
      '{'{OP_SECTOR,   8'h00, 19'd0},       1'b0, '0},
      '{'{OP_SECTOR,   8'h00, 19'd449849},  1'b0, '0},
      '{'{OP_SELECT,   8'h0F, 19'd0},       1'b0, '0},
      '{'{OP_READ,     8'h00, 19'd0},       1'b0, '0},
      '{'{OP_READ,     8'h00, 19'd0},       1'b0, '0},
      '{'{OP_SPARE_LO, 8'hFF, 19'h7FFFF},   1'b0, '0},
      '{'{OP_SPARE_HI, 8'hFF, 19'h7FFFF},   1'b0, '0},
      '{'{OP_SELECT,   8'h0F, 19'd0},       1'b0, '0},
      // Write to register 15 returns everything to its reset value.
      '{'{OP_WRITE,    8'h00, 19'd0},       1'b1, '{8'h00, 8'hFF, 16'h0000, 12'h000}}
   };

   // Random requests are shaped from the model's current state: a write that
   // would reset the whole register file is mostly turned into a read, the
   // decoder is mostly switched on when its control register is written,
   // and while it is off selects lean toward that register.
   function automatic req_type random_host_request();
      req_type     r;
      int unsigned pick;
      r.bus_data   = 8'($urandom);
      r.sector_lba = 19'($urandom_range(0, LBA_TOP));
      if ($urandom_range(0, 19) == 0) r.sector_lba = 19'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 12)      r.operation = OP_SELECT;
      else if (pick < 47) r.operation = OP_READ;
      else if (pick < 77) r.operation = OP_WRITE;
      else if (pick < 89) r.operation = OP_SECTOR;
      else if (pick < 97) r.operation = OP_XFER_END;
      else                r.operation = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
      if (r.operation == OP_WRITE && sel_reg == WR_FULL_RESET && $urandom_range(0, 9) != 0) begin
         r.operation = OP_READ;
      end
      if (r.operation == OP_WRITE && sel_reg == WR_CTRL0 && $urandom_range(0, 4) != 0) begin
         r.bus_data[7] = 1'b1;
      end
      if (!decode_en && r.operation == OP_SELECT && $urandom_range(0, 1) == 1) begin
         r.bus_data[3:0] = WR_CTRL0;
      end
      return r;
   endfunction

   // -------------------------------------------------------------------------
   // Request side. A request is held until the block takes it, then the
   // model is advanced and the result it owes is queued.
   // -------------------------------------------------------------------------
   task automatic send_host_request(input req_type r, input bit pinned, input rsp_type want);
      rsp_type due;
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      due = host_access_result(r);
      host_results_due.push_back(pinned ? want : due);
   endtask

   // Idle the request side for a short burst, with the given percent chance.
   task automatic request_gap(input int unsigned rate);
      if ($urandom_range(0, 99) < rate) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   // Stop offering requests until the block has returned every result.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (host_results_due.size() != 0) @(posedge clock);
   endtask

   initial begin : drive_requests
      int unsigned gap_rate;
      clear_register_file();
      gap_rate = 20;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (opening[i]) begin
         request_gap(gap_rate);
         send_host_request(opening[i].req, opening[i].pinned, opening[i].want);
      end
      wait_for_drain();

      // The idle rate of the request side changes every few dozen requests,
      // and some stretches run with none at all.
      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         if (n % 60 == 0) gap_rate = $urandom_range(0, 3) * 12;
         if (n == RANDOM_REQUESTS / 2) wait_for_drain();
         if (n >= RANDOM_REQUESTS - QUIET_TAIL) begin
            quiet_tail = 1'b1;
         end else begin
            request_gap(gap_rate);
         end
         send_host_request(random_host_request(), 1'b0, '0);
      end
      req_valid <= 1'b0;

      while (host_results_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("cdrom_host_interface_registers_unit verification clean");
      end else begin
         $display("cdrom_host_interface_registers_unit verification failed");
      end
      $finish;
   end

   // -------------------------------------------------------------------------
   // Result side. Stalls come in short random bursts at a rate that changes
   // over the run, plus one long hold-off once enough results have passed,
   // long enough for the block to fill and push back on requests. The last
   // stretch of the run has no stalls.
   // -------------------------------------------------------------------------
   initial begin : drive_result_stall
      int unsigned rate;
      int unsigned span;
      bit          held;
      rate = 0;
      span = 0;
      held = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         span++;
         if (span % 50 == 0) rate = $urandom_range(0, 3) * 12;
         if (quiet_tail) begin
            rsp_stall <= 1'b0;
         end else if (!held && results_checked >= HOLD_OFF_AFTER) begin
            held = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if ($urandom_range(0, 99) < rate) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 5)) @(posedge clock);
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Only the first ten failures are printed; the rest are counted.
   task automatic note_failure(input string what);
      mismatches++;
      if (mismatches <= 10) $display("%s", what);
   endtask

   // Each accepted result is compared field by field with the oldest one owed.
   always @(posedge clock) begin : check_results
      rsp_type due;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (host_results_due.size() == 0) begin
            note_failure($sformatf("result with no request behind it: %p", rsp_data));
         end else begin
            due = host_results_due.pop_front();
            results_checked++;
            if (rsp_data.read_data !== due.read_data
                || rsp_data.interrupt_status !== due.interrupt_status
                || rsp_data.transfer_address !== due.transfer_address
                || rsp_data.transfer_count !== due.transfer_count) begin
               note_failure($sformatf(
                  "result %0d: read_data %h/%h status %h/%h address %h/%h count %h/%h (exp/got)",
                  results_checked, due.read_data, rsp_data.read_data,
                  due.interrupt_status, rsp_data.interrupt_status,
                  due.transfer_address, rsp_data.transfer_address,
                  due.transfer_count, rsp_data.transfer_count));
            end
         end
      end
   end

endmodule
